// ===== sv/swtm_pkg.sv =====
`timescale 1ns / 1ps

package swtm_pkg;

  localparam int MAX_WINDOW    = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int WIN_BITS      = 7;
  localparam int TRIM_BITS     = 5;
  localparam int PTR_BITS      = $clog2(MAX_WINDOW);
  localparam int SUM_BITS      = SAMPLE_BITS + PTR_BITS;
  localparam int CNT_BITS      = $clog2(SUM_BITS + 1);
  localparam int MEAN_BITS     = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 7;

  localparam logic [WIN_BITS-1:0]     WIN_MAX      = WIN_BITS'(MAX_WINDOW);
  localparam logic [WIN_BITS-1:0]     WINDOW_RESET = WIN_BITS'(64);
  localparam logic [TRIM_BITS-1:0]    TRIM_RESET   = TRIM_BITS'(1);

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_TRIM_COUNT  = CFG_IDX_BITS'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_DRAIN,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN
  } state_t;

  // sequencer to cell chain
  typedef struct packed {
    logic                shift;
    logic                step;
    logic [PTR_BITS-1:0] k;
  } rank_ctrl_t;

  // one ranked sample back from the cell chain
  typedef struct packed {
    logic                   valid;
    logic                   incl;
    logic [SAMPLE_BITS-1:0] value;
  } rank_res_t;

endpackage

// ===== sv/swtm_rank.sv =====
`timescale 1ns / 1ps

module swtm_rank (
  input  logic                                clk,
  input  logic                                rst,
  input  swtm_pkg::rank_ctrl_t                ctrl,
  input  logic [swtm_pkg::SAMPLE_BITS-1:0]    sample,
  input  logic [swtm_pkg::WIN_BITS-1:0]       win,
  input  logic [swtm_pkg::TRIM_BITS-1:0]      trim,
  output swtm_pkg::rank_res_t                 res
);

  // cells[i] holds the sample of age i; scan walks the window past slot 0
  logic [swtm_pkg::SAMPLE_BITS-1:0] cells [swtm_pkg::MAX_WINDOW];
  logic [swtm_pkg::SAMPLE_BITS-1:0] scan  [swtm_pkg::MAX_WINDOW];
  logic [swtm_pkg::MAX_WINDOW-1:0]  below;
  logic [swtm_pkg::WIN_BITS-1:0]    rank;
  logic [swtm_pkg::WIN_BITS-1:0]    hi;
  logic [swtm_pkg::WIN_BITS-1:0]    lo;
  logic                             incl;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      cells[0] <= sample;
      scan[0]  <= sample;
      for (int i = 1; i < swtm_pkg::MAX_WINDOW; i++) begin
        cells[i] <= cells[i-1];
        scan[i]  <= cells[i-1];
      end
    end else if (ctrl.step) begin
      for (int i = 0; i < swtm_pkg::MAX_WINDOW - 1; i++) begin
        scan[i] <= scan[i+1];
      end
    end
  end

  // rank of scan[0]: smaller values, ties broken by age
  always_comb begin
    for (int j = 0; j < swtm_pkg::MAX_WINDOW; j++) begin
      below[j] = (swtm_pkg::WIN_BITS'(j) < win) &&
                 ((cells[j] < scan[0]) ||
                  ((cells[j] == scan[0]) && (swtm_pkg::PTR_BITS'(j) < ctrl.k)));
    end
    rank = swtm_pkg::WIN_BITS'($countones(below));
    lo   = {2'b00, trim};
    hi   = win - lo;
    incl = (rank >= lo) && (rank < hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= ctrl.step;
    end
    res.incl  <= incl;
    res.value <= scan[0];
  end

endmodule

// ===== sv/swtm_div.sv =====
`timescale 1ns / 1ps

module swtm_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [swtm_pkg::SUM_BITS-1:0]     dividend,
  input  logic [swtm_pkg::WIN_BITS-1:0]     divisor,
  output logic                              done,
  output logic [swtm_pkg::MEAN_BITS-1:0]    quotient
);

  localparam logic [swtm_pkg::CNT_BITS-1:0] LAST =
    swtm_pkg::CNT_BITS'(swtm_pkg::SUM_BITS - 1);

  logic                              busy;
  logic [swtm_pkg::CNT_BITS-1:0]     cnt;
  logic [swtm_pkg::WIN_BITS-1:0]     rem;
  logic [swtm_pkg::SUM_BITS-1:0]     quo;
  logic [swtm_pkg::WIN_BITS:0]       r2;
  logic [swtm_pkg::WIN_BITS:0]       diff;
  logic                              ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    r2   = {rem, quo[swtm_pkg::SUM_BITS-1]};
    diff = r2 - {1'b0, divisor};
    ge   = (r2 >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[swtm_pkg::WIN_BITS-1:0] : r2[swtm_pkg::WIN_BITS-1:0];
      quo <= {quo[swtm_pkg::SUM_BITS-2:0], ge};
    end
  end

  assign quotient = quo[swtm_pkg::MEAN_BITS-1:0];

endmodule

// ===== sv/sliding_window_trimmed_mean.sv =====
`timescale 1ns / 1ps
// Sliding-window trimmed mean.
// Input channel (in_valid/in_ready, sample): one unsigned sample per item.
// Output channel (out_valid/out_ready, mean_valid, trimmed_mean): one result
// per input item, in order. mean_valid is low, and trimmed_mean zero, until
// window_size samples have arrived or when twice trim_count reaches it.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 writes
// window_size, index 1 trim_count; other indexes are dropped. Always ready.
// Write only between items.
// An item with a full window is ranked one window sample a cycle (window
// size capped at 64) against every sample in the window; then the chain
// is drained, the 22-step bit-serial divider runs and the output is
// loaded. An invalid result skips ranking and division and goes straight
// to the output stage. in_ready is high only in the idle state, so a new
// item is taken only after the last one is handed to the output register.
// A finished result sits in the output register; the next item is taken
// while it waits, and only the final hand-over stalls on out_ready.
// Reset clears the sample count, the output valid and the registers to
// window_size 64, trim_count 1.

module sliding_window_trimmed_mean (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [swtm_pkg::SAMPLE_BITS-1:0]      sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  mean_valid,
  output logic [swtm_pkg::MEAN_BITS-1:0]        trimmed_mean,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swtm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [swtm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  swtm_pkg::state_t                   state, state_next;
  swtm_pkg::rank_ctrl_t               ctrl;
  swtm_pkg::rank_res_t                rres;

  logic [swtm_pkg::WIN_BITS-1:0]      window_size;
  logic [swtm_pkg::TRIM_BITS-1:0]     trim_count;
  logic [swtm_pkg::WIN_BITS-1:0]      fill;
  logic [swtm_pkg::WIN_BITS-1:0]      fill_next;
  logic [swtm_pkg::PTR_BITS-1:0]      k;
  logic [swtm_pkg::SUM_BITS-1:0]      middle_sum;
  logic                               res_ok;

  logic [swtm_pkg::WIN_BITS-1:0]      win;
  logic [swtm_pkg::WIN_BITS-1:0]      twice_trim;
  logic [swtm_pkg::WIN_BITS-1:0]      divisor;
  logic                               bad_next;
  logic                               div_start;
  logic                               div_done;
  logic [swtm_pkg::MEAN_BITS-1:0]     div_quot;
  logic                               out_load;

  assign cfg_ready = 1'b1;

  // effective window and the checks made as an item enters
  always_comb begin
    win        = (window_size > swtm_pkg::WIN_MAX) ? swtm_pkg::WIN_MAX : window_size;
    twice_trim = {1'b0, trim_count, 1'b0};
    divisor    = win - twice_trim;
    fill_next  = (fill == swtm_pkg::WIN_MAX) ? fill : fill + 1'b1;
    bad_next   = (win == '0) || (fill_next < win) || (twice_trim >= win);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swtm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctrl       = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      swtm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.shift = 1'b1;
          state_next = bad_next ? swtm_pkg::ST_FIN : swtm_pkg::ST_RANK;
        end
      end
      swtm_pkg::ST_RANK: begin
        ctrl.step = 1'b1;
        ctrl.k    = k;
        if ({1'b0, k} == win - 1'b1) begin
          state_next = swtm_pkg::ST_DRAIN;
        end
      end
      swtm_pkg::ST_DRAIN: begin
        state_next = swtm_pkg::ST_DSTART;
      end
      swtm_pkg::ST_DSTART: begin
        div_start  = 1'b1;
        state_next = swtm_pkg::ST_DWAIT;
      end
      swtm_pkg::ST_DWAIT: begin
        if (div_done) begin
          state_next = swtm_pkg::ST_FIN;
        end
      end
      swtm_pkg::ST_FIN: begin
        // hand over once the output register is free
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = swtm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swtm_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swtm_pkg::WINDOW_RESET;
      trim_count  <= swtm_pkg::TRIM_RESET;
      fill        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == swtm_pkg::REG_WINDOW_SIZE) begin
          window_size <= cfg_data[swtm_pkg::WIN_BITS-1:0];
        end else if (cfg_index == swtm_pkg::REG_TRIM_COUNT) begin
          trim_count <= cfg_data[swtm_pkg::TRIM_BITS-1:0];
        end
      end
      if (ctrl.shift) begin
        fill <= fill_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      res_ok     <= !bad_next;
      k          <= '0;
      middle_sum <= '0;
    end else begin
      if (ctrl.step) begin
        k <= k + 1'b1;
      end
      if (rres.valid && rres.incl) begin
        middle_sum <= middle_sum + swtm_pkg::SUM_BITS'(rres.value);
      end
    end
    if (out_load) begin
      mean_valid   <= res_ok;
      trimmed_mean <= res_ok ? div_quot : '0;
    end
  end

  swtm_rank u_rank (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (sample),
    .win    (win),
    .trim   (trim_count),
    .res    (rres)
  );

  swtm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (middle_sum),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

// ===== sim/sliding_window_trimmed_mean_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_trimmed_mean_tb;
  import swtm_pkg::*;

  // indexes the block must ignore
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = CFG_IDX_BITS'(3);

  // cycles with no item moving on any channel before the run is called hung;
  // the limit lies well above the slowest item (full 64 window), the sender's
  // longest gap and the receiver's longest stall
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 400;
  localparam int TAIL_CYCLES   = 120;

  typedef struct packed {
    logic                 ok;
    logic [MEAN_BITS-1:0] mean;
  } mean_result_t;

  // Scoreboard: keeps its own copy of the sample ring and the registers and
  // works out the trimmed mean each sample should give.
  class mean_scoreboard;
    logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    int unsigned            ring_ptr;
    int unsigned            samples_seen;   // saturates at MAX_WINDOW
    logic [WIN_BITS-1:0]    window_reg;
    logic [TRIM_BITS-1:0]   trim_reg;
    mean_result_t           means_due[$];
    int unsigned            mismatches;
    int unsigned            results_checked;
    int unsigned            valid_means;

    function new();
      ring_ptr        = 0;
      samples_seen    = 0;
      window_reg      = WINDOW_RESET;
      trim_reg        = TRIM_RESET;
      mismatches      = 0;
      results_checked = 0;
      valid_means     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_BITS-1:0] idx,
                                 logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_WINDOW_SIZE: window_reg = data;
        REG_TRIM_COUNT:  trim_reg   = data[TRIM_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS-1:0] vals [MAX_WINDOW];
      logic [SAMPLE_BITS-1:0] v;
      int unsigned            w;
      int unsigned            j;
      int unsigned            total;
      mean_result_t           res;
      ring[ring_ptr] = s;
      ring_ptr = (ring_ptr + 1) % MAX_WINDOW;
      if (samples_seen < MAX_WINDOW) samples_seen++;
      w = (int'(window_reg) > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg);
      res = '0;
      if (w != 0 && samples_seen >= w && 2 * int'(trim_reg) < w) begin
        // insertion sort of the w newest samples
        for (int i = 0; i < w; i++) begin
          v = ring[(ring_ptr + MAX_WINDOW - 1 - i) % MAX_WINDOW];
          j = i;
          while (j > 0 && vals[j-1] > v) begin
            vals[j] = vals[j-1];
            j--;
          end
          vals[j] = v;
        end
        total = 0;
        for (int i = int'(trim_reg); i < w - int'(trim_reg); i++) total += vals[i];
        res.ok   = 1'b1;
        res.mean = MEAN_BITS'(total / (w - 2 * int'(trim_reg)));
      end
      means_due = {means_due, res};
    endfunction

    function void check_result(logic ok, logic [MEAN_BITS-1:0] mean);
      mean_result_t due;
      results_checked++;
      if (means_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing outstanding: valid=%0b mean=%0d",
                   $realtime, ok, mean);
        return;
      end
      due = means_due.pop_front();
      if (due.ok) valid_means++;
      if (ok !== due.ok || mean !== due.mean) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: expected valid=%0b mean=%0d, got valid=%0b mean=%0d",
                   $realtime, due.ok, due.mean, ok, mean);
      end
    endfunction

    function int unsigned outstanding();
      return means_due.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [SAMPLE_BITS-1:0]   sample;
  logic                     out_valid;
  logic                     out_ready;
  logic                     mean_valid;
  logic [MEAN_BITS-1:0]     trimmed_mean;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  mean_scoreboard sb = new();

  int unsigned burst_left;
  int unsigned samples_sent;
  int unsigned settings_used;
  int unsigned idle_cycles;

  // receiver stall pattern: rotated every cycle, reloaded now and then
  logic [15:0] ready_pattern;
  int unsigned pattern_hold;

  sliding_window_trimmed_mean u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mean_valid   (mean_valid),
    .trimmed_mean (trimmed_mean),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Receiver. Modes: no stalls at all, random stalls, mostly stalled. The
  // low bit is forced so every rotation of the pattern is ready at least once.
  initial begin
    ready_pattern = 16'hFFFF;
    pattern_hold  = 0;
    out_ready     = 1'b0;
  end

  always @(posedge clk) begin
    if (pattern_hold == 0) begin
      pattern_hold = $urandom_range(20, 200);
      case ($urandom_range(0, 2))
        0:       ready_pattern = 16'hFFFF;
        1:       ready_pattern = 16'($urandom()) | 16'h0001;
        default: ready_pattern = 16'($urandom() & $urandom()) | 16'h0001;
      endcase
    end else begin
      pattern_hold--;
    end
    out_ready     <= ready_pattern[0];
    ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
  end

  // results are checked as they are handed over
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(mean_valid, trimmed_mean);
  end

  // watchdog: any item moving on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no progress for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, sb.outstanding());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One sample item. The sender runs in bursts; at the start of a burst it
  // may drop valid for a random gap. Valid is never dropped and raised in
  // the same step.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(v);
    samples_sent++;
  endtask

  // drop valid and wait for every outstanding result, so the block is idle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic put_register(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
  endtask

  // Back-to-back register writes with valid held high; optionally writes to
  // spare indexes, which must change nothing. Only called with the block idle.
  task automatic write_registers(input logic [CFG_DATA_BITS-1:0] win,
                                 input logic [CFG_DATA_BITS-1:0] trim,
                                 input bit spare);
    if (spare && $urandom_range(0, 1)) put_register(REG_SPARE_A, 7'($urandom()));
    put_register(REG_WINDOW_SIZE, win);
    put_register(REG_TRIM_COUNT, trim);
    if (spare) put_register(REG_SPARE_B, 7'($urandom()));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned            w_eff;
    int unsigned            n_items;
    int unsigned            mode;
    int unsigned            pick;
    logic [CFG_DATA_BITS-1:0] win;
    logic [CFG_DATA_BITS-1:0] trim;
    logic [SAMPLE_BITS-1:0] s;

    rst           <= 1'b1;
    in_valid      <= 1'b0;
    sample        <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    burst_left    = 0;
    samples_sent  = 0;
    settings_used = 0;
    idle_cycles   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // reset registers (64, 1): window far from full, all invalid
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hAAAA);
    drain_results();

    // shrink to 3 mid-stream: history kept, so valid at once
    write_registers(7'd3, 7'd1, 1'b0);
    send_sample(16'h5555);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'hFFFE);
    drain_results();

    // trim too large for the window
    write_registers(7'd4, 7'd2, 1'b0);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    drain_results();

    // zero window, plus writes to spare indexes
    write_registers(7'd0, 7'd0, 1'b1);
    send_sample(16'h1234);
    send_sample(16'hFFFF);
    drain_results();

    // tiny windows with no trimming
    write_registers(7'd1, 7'd0, 1'b0);
    send_sample(16'hFFFF);
    send_sample(16'h0003);
    drain_results();
    write_registers(7'd2, 7'd0, 1'b0);
    send_sample(16'hFFFF);
    send_sample(16'hFFFE);
    drain_results();

    // oversize window saturates to 64; not enough samples yet
    write_registers(7'd127, 7'd0, 1'b0);
    send_sample(16'h0F0F);
    send_sample(16'hF0F0);
    drain_results();

    // upper trim data bits are dropped: 33 leaves a trim of 1
    write_registers(7'd5, 7'd33, 1'b1);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h4321);
    drain_results();

    // --- random part: phases of one register setting each ---
    while (samples_sent < RANDOM_ITEMS + 21) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      win = 7'($urandom_range(3, 12));
      else if (pick < 75) win = 7'($urandom_range(13, 63));
      else if (pick < 85) win = 7'd64;
      else if (pick < 92) win = 7'($urandom_range(65, 127));
      else                win = 7'($urandom_range(0, 2));
      w_eff = (win > 64) ? 64 : win;

      // mostly a trim that leaves values; sometimes raw data, sometimes the
      // smallest trim that empties the window
      pick = $urandom_range(0, 99);
      if (pick < 75)      trim = 7'($urandom_range(0, (w_eff == 0) ? 0 : (w_eff - 1) / 2));
      else if (pick < 90) trim = 7'($urandom());
      else                trim = 7'((w_eff + 1) / 2);

      write_registers(win, trim, $urandom_range(0, 7) == 0);

      n_items = $urandom_range(8, 40);
      mode    = $urandom_range(0, 3);
      repeat (n_items) begin
        case (mode)
          0: s = 16'($urandom());
          1: s = 16'($urandom_range(0, 15));           // many duplicates
          2: begin
            pick = $urandom_range(0, 2);
            s = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom());
          end
          default: s = 16'($urandom_range(65500, 65535));  // sums near the top
        endcase
        send_sample(s);
      end
      drain_results();
    end

    // quiet tail: catches any stray result
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d samples under %0d register settings.", samples_sent, settings_used);
    $display("Checked %0d results, %0d of them valid means, %0d mismatches.",
             sb.results_checked, sb.valid_means, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (sb.outstanding() != 0)
        $display("%0d expected results never arrived", sb.outstanding());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
